@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ rtl/core/hrbp_pkg.sv @@
package hrbp_pkg;

    localparam int DEF_LENGTH_BITS = 32;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 3;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Length of "Content-Length"
    localparam logic [3:0] KEY_LEN = 4'd14;

    // Phase codes as seen on the output
    localparam logic [1:0] PHASE_CODE_STATUS  = 2'd0;
    localparam logic [1:0] PHASE_CODE_HEADERS = 2'd1;
    localparam logic [1:0] PHASE_CODE_BODY    = 2'd2;
    localparam logic [1:0] PHASE_CODE_DONE    = 2'd3;

    typedef enum logic [3:0] {
        PH_STATUS  = 4'b0001,
        PH_HEADERS = 4'b0010,
        PH_BODY    = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        KEY_MATCHING = 3'b001,
        KEY_FAILED   = 3'b010,
        KEY_MATCHED  = 3'b100
    } t_key_st;

    typedef enum logic [3:0] {
        NUM_WS     = 4'b0001,
        NUM_SIGN   = 4'b0010,
        NUM_DIGITS = 4'b0100,
        NUM_DONE   = 4'b1000
    } t_num_st;

    typedef struct packed {
        t_phase     phase;
        logic [1:0] line_count;
        logic       prev_cr;
        logic [3:0] key_index;
        t_key_st    key_st;
        logic       space_found;
        t_num_st    num_st;
        logic       num_sign;
        logic       length_seen;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{
        phase:       PH_STATUS,
        line_count:  2'd0,
        prev_cr:     1'b0,
        key_index:   4'd0,
        key_st:      KEY_MATCHING,
        space_found: 1'b0,
        num_st:      NUM_WS,
        num_sign:    1'b0,
        length_seen: 1'b0
    };

    typedef struct packed {
        logic [1:0] phase;
        logic       st_done;
        logic       hl_done;
        logic       h_done;
        logic       is_body;
        logic       body_last;
        logic       length_known;
    } t_flags;

    function automatic logic [1:0] phase_code(t_phase p);
        logic [1:0] code;
        case (p)
            PH_STATUS:  code = PHASE_CODE_STATUS;
            PH_HEADERS: code = PHASE_CODE_HEADERS;
            PH_BODY:    code = PHASE_CODE_BODY;
            PH_DONE:    code = PHASE_CODE_DONE;
            default:    code = PHASE_CODE_STATUS;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] key_char(logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/hrbp_step.sv @@
module hrbp_step #(
    parameter int LENGTH_BITS = hrbp_pkg::DEF_LENGTH_BITS
) (
    input  logic [7:0]             i_byte,
    input  hrbp_pkg::t_ctl         i_ctl,
    input  logic [LENGTH_BITS-1:0] i_accum,
    input  logic [LENGTH_BITS-1:0] i_left,
    output hrbp_pkg::t_ctl         o_ctl,
    output logic [LENGTH_BITS-1:0] o_accum,
    output logic [LENGTH_BITS-1:0] o_left,
    output hrbp_pkg::t_flags       o_flags,
    output logic [31:0]            o_body_length
);

    localparam logic [LENGTH_BITS-1:0] ONE   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    localparam logic [LENGTH_BITS-1:0] LSIGN = {1'b1, {(LENGTH_BITS-1){1'b0}}};
    localparam logic [LENGTH_BITS-1:0] LMAX  = {1'b0, {(LENGTH_BITS-1){1'b1}}};
    // Saturation limit (LSIGN - d) / 10 is SAT_Q for d <= SAT_R, else SAT_Q - 1
    localparam logic [LENGTH_BITS-1:0] SAT_Q    = LSIGN / 10;
    localparam logic [LENGTH_BITS-1:0] SAT_Q_M1 = SAT_Q - ONE;
    localparam logic [3:0]             SAT_R    = 4'(LSIGN % 10);

    logic                   crlf;
    logic                   is_ws;
    logic                   is_digit;
    logic                   is_sign;
    logic [3:0]             digit;
    logic [LENGTH_BITS-1:0] sat_limit;
    logic                   over;
    logic [LENGTH_BITS+3:0] times10;
    logic [LENGTH_BITS-1:0] mag;
    logic [LENGTH_BITS-1:0] value;
    logic                   line_rst;
    logic [63:0]            accum_ext;

    assign crlf     = (i_byte == hrbp_pkg::CHAR_LF) && i_ctl.prev_cr;
    assign is_ws    = (i_byte == hrbp_pkg::CHAR_SPACE) ||
                      (i_byte inside {[hrbp_pkg::CHAR_TAB:hrbp_pkg::CHAR_CR]});
    assign is_digit = i_byte inside {[hrbp_pkg::CHAR_ZERO:hrbp_pkg::CHAR_NINE]};
    assign is_sign  = (i_byte == hrbp_pkg::CHAR_PLUS) || (i_byte == hrbp_pkg::CHAR_MINUS);
    assign digit    = 4'(i_byte - hrbp_pkg::CHAR_ZERO);

    assign sat_limit = (digit <= SAT_R) ? SAT_Q : SAT_Q_M1;
    assign over      = i_accum > sat_limit;
    assign times10   = ({4'b0, i_accum} << 3) + ({4'b0, i_accum} << 1)
                       + {{LENGTH_BITS{1'b0}}, digit};

    // A CR LF never moves the accumulator, so the value comes from it directly
    assign mag   = (i_accum > LSIGN) ? LSIGN : i_accum;
    assign value = i_ctl.num_sign ? (~mag + ONE) : ((i_accum > LMAX) ? LMAX : i_accum);

    always_comb begin
        o_ctl    = i_ctl;
        o_accum  = i_accum;
        o_left   = i_left;
        o_flags  = '0;
        line_rst = 1'b0;

        case (i_ctl.phase)
            hrbp_pkg::PH_STATUS: begin
                if (crlf) begin
                    o_flags.st_done = 1'b1;
                    o_ctl.phase     = hrbp_pkg::PH_HEADERS;
                    line_rst        = 1'b1;
                end else begin
                    o_ctl.prev_cr = (i_byte == hrbp_pkg::CHAR_CR);
                end
            end
            hrbp_pkg::PH_HEADERS: begin
                if (crlf && i_ctl.line_count == 2'd1) begin
                    // blank line: header section over
                    o_flags.h_done = 1'b1;
                    o_left         = i_ctl.length_seen ? i_accum : '0;
                    o_ctl.phase    = hrbp_pkg::PH_BODY;
                    line_rst       = 1'b1;
                end else begin
                    if (i_ctl.key_st == hrbp_pkg::KEY_MATCHING) begin
                        if (i_byte == hrbp_pkg::CHAR_COLON) begin
                            o_ctl.key_st = (i_ctl.key_index == hrbp_pkg::KEY_LEN) ?
                                           hrbp_pkg::KEY_MATCHED : hrbp_pkg::KEY_FAILED;
                        end else if (i_ctl.key_index < hrbp_pkg::KEY_LEN &&
                                     i_byte == hrbp_pkg::key_char(i_ctl.key_index)) begin
                            o_ctl.key_index = i_ctl.key_index + 4'd1;
                        end else begin
                            o_ctl.key_st = hrbp_pkg::KEY_FAILED;
                        end
                    end

                    if (!i_ctl.length_seen && i_ctl.space_found &&
                        i_ctl.num_st != hrbp_pkg::NUM_DONE) begin
                        if (i_ctl.num_st == hrbp_pkg::NUM_WS && is_ws) begin
                            o_ctl.num_st = hrbp_pkg::NUM_WS;
                        end else if (i_ctl.num_st == hrbp_pkg::NUM_WS && is_sign) begin
                            o_ctl.num_sign = (i_byte == hrbp_pkg::CHAR_MINUS);
                            o_ctl.num_st   = hrbp_pkg::NUM_SIGN;
                        end else if (!is_digit) begin
                            o_ctl.num_st = hrbp_pkg::NUM_DONE;
                        end else begin
                            o_ctl.num_st = hrbp_pkg::NUM_DIGITS;
                            o_accum      = over ? LSIGN : times10[LENGTH_BITS-1:0];
                        end
                    end

                    if (i_byte == hrbp_pkg::CHAR_SPACE) begin
                        o_ctl.space_found = 1'b1;
                    end

                    if (crlf) begin
                        o_flags.hl_done = 1'b1;
                        if (o_ctl.key_st == hrbp_pkg::KEY_MATCHED && o_ctl.space_found &&
                            !i_ctl.length_seen) begin
                            o_accum           = value;
                            o_ctl.length_seen = 1'b1;
                        end
                        line_rst = 1'b1;
                    end else begin
                        o_ctl.prev_cr = (i_byte == hrbp_pkg::CHAR_CR);
                        if (i_ctl.line_count != 2'd3) begin
                            o_ctl.line_count = i_ctl.line_count + 2'd1;
                        end
                    end
                end
            end
            hrbp_pkg::PH_BODY: begin
                o_flags.is_body = 1'b1;
                if (i_left <= ONE || i_left[LENGTH_BITS-1]) begin
                    o_flags.body_last = 1'b1;
                    o_ctl.phase       = hrbp_pkg::PH_DONE;
                end
                o_left = i_left - ONE;
            end
            default: begin
                // complete: bytes are only echoed
            end
        endcase

        if (line_rst) begin
            o_ctl.line_count  = 2'd0;
            o_ctl.prev_cr     = 1'b0;
            o_ctl.key_index   = 4'd0;
            o_ctl.key_st      = hrbp_pkg::KEY_MATCHING;
            o_ctl.space_found = 1'b0;
            o_ctl.num_st      = hrbp_pkg::NUM_WS;
            o_ctl.num_sign    = 1'b0;
            if (!o_ctl.length_seen) begin
                o_accum = '0;
            end
        end

        o_flags.phase        = hrbp_pkg::phase_code(o_ctl.phase);
        o_flags.length_known = o_ctl.length_seen;
    end

    assign accum_ext     = 64'(o_accum);
    assign o_body_length = o_ctl.length_seen ? accum_ext[31:0] : 32'd0;

endmodule

@@ rtl/core/http_response_byte_parser_top.sv @@
// HTTP response parser, Content-Length framing. Takes one response byte per
// transfer and returns one result per byte, one byte per clock while neither
// side stalls. Each byte is held in an input register, then goes through the
// combinational parse step that updates the line and number state and loads
// the result register. The status line is skipped, header lines are scanned
// for Content-Length (first match wins, value saturated to LENGTH_BITS signed),
// and body bytes count the length down; tlast marks the byte that completes
// the body. The body_length field carries the low 32 bits of the accepted
// value. Either side may stall at any time.
module http_response_byte_parser_top #(
    parameter int LENGTH_BITS = hrbp_pkg::DEF_LENGTH_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] rx_byte
    input  logic [hrbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] byte_echo, [8] status_line_done, [9] header_line_done,
    // [10] headers_done, [11] length_known, [43:12] body_length, [47:44] zero
    output logic [hrbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] phase, [2] is_body
    output logic [hrbp_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    // body_last
    output logic                             m_axis_tlast
);

    logic                   advance;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;

    hrbp_pkg::t_ctl         r_ctl;
    hrbp_pkg::t_ctl         n_ctl;
    logic [LENGTH_BITS-1:0] r_accum;
    logic [LENGTH_BITS-1:0] n_accum;
    logic [LENGTH_BITS-1:0] r_left;
    logic [LENGTH_BITS-1:0] n_left;

    hrbp_pkg::t_flags       n_flags;
    logic [31:0]            n_body_length;

    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    hrbp_pkg::t_flags       r_out_flags;
    logic [31:0]            r_out_body_length;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    hrbp_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .i_byte        (r_in_byte),
        .i_ctl         (r_ctl),
        .i_accum       (r_accum),
        .i_left        (r_left),
        .o_ctl         (n_ctl),
        .o_accum       (n_accum),
        .o_left        (n_left),
        .o_flags       (n_flags),
        .o_body_length (n_body_length)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl       <= hrbp_pkg::CTL_RESET;
            r_accum     <= '0;
            r_left      <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && advance) begin
                r_ctl   <= n_ctl;
                r_accum <= n_accum;
                r_left  <= n_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata[7:0];
        end
        if (r_in_valid && advance) begin
            r_out_byte        <= r_in_byte;
            r_out_flags       <= n_flags;
            r_out_body_length <= n_body_length;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_body_length, r_out_flags.length_known,
                            r_out_flags.h_done, r_out_flags.hl_done, r_out_flags.st_done,
                            r_out_byte};
    assign m_axis_tuser  = {r_out_flags.is_body, r_out_flags.phase};
    assign m_axis_tlast  = r_out_flags.body_last;

endmodule

@@ rtl/core/hrbp_checker.sv @@
`include "assert_macros.svh"

module hrbp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [hrbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [hrbp_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                             m_axis_tlast
);

    // no result may appear straight out of reset
    `ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid)

    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // the completing byte is a body byte and leaves the parser complete
    `ASSERT_CLK(a_last_is_body, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tlast |->
        m_axis_tuser[2] && m_axis_tuser[1:0] == hrbp_pkg::PHASE_CODE_DONE)

    // blank line after the headers moves to the body and is not a body byte
    `ASSERT_CLK(a_hdone_phase, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[10] |->
        m_axis_tuser[1:0] == hrbp_pkg::PHASE_CODE_BODY && !m_axis_tuser[2])

    `ASSERT_CLK(a_len_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tdata[11] |-> m_axis_tdata[43:12] == 32'd0)

endmodule

bind http_response_byte_parser_top hrbp_checker u_hrbp_checker (.*);

@@ tb/sv/http_response_byte_parser_top_tb.sv @@
`timescale 1ns / 100ps

module http_response_byte_parser_top_tb;

    localparam int ITEM_GOAL    = 500;
    localparam int CALM_ITEMS   = 60;
    localparam int HEADER_BYTES = 250;
    localparam int MAX_BODY     = 200;
    localparam logic [63:0] LEN_MASK = (64'd1 << hrbp_pkg::DEF_LENGTH_BITS) - 64'd1;
    localparam logic [63:0] LEN_SIGN = 64'd1 << (hrbp_pkg::DEF_LENGTH_BITS - 1);
    localparam string CL_KEY = "Content-Length";

    typedef struct packed {
        logic [7:0]  echo;
        logic [1:0]  phase;
        logic        st_done;
        logic        hl_done;
        logic        h_done;
        logic        is_body;
        logic        body_last;
        logic        len_known;
        logic [31:0] body_len;
    } t_parse_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [hrbp_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [hrbp_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [hrbp_pkg::OUT_TUSER_W-1:0] m_tuser;
    logic m_tlast;

    http_response_byte_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // parser state mirror
    logic [1:0]        ps_phase = hrbp_pkg::PHASE_CODE_STATUS;
    logic [1:0]        ps_line_count = 2'd0;
    logic              ps_prev_cr = 1'b0;
    logic [3:0]        ps_key_idx = 4'd0;
    hrbp_pkg::t_key_st ps_key_st = hrbp_pkg::KEY_MATCHING;
    logic              ps_space = 1'b0;
    hrbp_pkg::t_num_st ps_num_st = hrbp_pkg::NUM_WS;
    logic              ps_neg = 1'b0;
    logic              ps_len_seen = 1'b0;
    logic [63:0]       ps_accum = '0;
    logic [63:0]       ps_left = '0;

    t_parse_out parser_out_q[$];
    int  mismatches = 0;
    int  sent_count = 0;
    bit  calm = 1'b0;

    function automatic bit is_atoi_space(logic [7:0] c);
        return c == hrbp_pkg::CHAR_SPACE ||
               (c >= hrbp_pkg::CHAR_TAB && c <= hrbp_pkg::CHAR_CR);
    endfunction

    function automatic void clear_line();
        ps_line_count = 2'd0;
        ps_prev_cr = 1'b0;
        ps_key_idx = 4'd0;
        ps_key_st = hrbp_pkg::KEY_MATCHING;
        ps_space = 1'b0;
        ps_num_st = hrbp_pkg::NUM_WS;
        ps_neg = 1'b0;
        if (!ps_len_seen) ps_accum = '0;
    endfunction

    function automatic void feed_number(logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c} - {56'd0, hrbp_pkg::CHAR_ZERO};
        if (ps_num_st == hrbp_pkg::NUM_DONE) return;
        if (ps_num_st == hrbp_pkg::NUM_WS) begin
            if (is_atoi_space(c)) return;
            if (c == hrbp_pkg::CHAR_PLUS || c == hrbp_pkg::CHAR_MINUS) begin
                ps_neg = (c == hrbp_pkg::CHAR_MINUS);
                ps_num_st = hrbp_pkg::NUM_SIGN;
                return;
            end
        end
        if (c < hrbp_pkg::CHAR_ZERO || c > hrbp_pkg::CHAR_NINE) begin
            ps_num_st = hrbp_pkg::NUM_DONE;
            return;
        end
        ps_num_st = hrbp_pkg::NUM_DIGITS;
        // magnitude sticks at 2^(N-1) once it would pass it
        if (ps_accum > (LEN_SIGN - d) / 64'd10)
            ps_accum = LEN_SIGN;
        else
            ps_accum = ps_accum * 64'd10 + d;
    endfunction

    function automatic logic [63:0] clamped_length();
        logic [63:0] m;
        m = ps_accum;
        if (ps_neg) return (64'd0 - ((m > LEN_SIGN) ? LEN_SIGN : m)) & LEN_MASK;
        return (m > LEN_SIGN - 64'd1) ? LEN_SIGN - 64'd1 : m;
    endfunction

    function automatic t_parse_out parse_byte(logic [7:0] c);
        t_parse_out r;
        logic crlf;
        crlf = (c == hrbp_pkg::CHAR_LF) && ps_prev_cr;
        r = '0;
        r.echo = c;
        case (ps_phase)
            hrbp_pkg::PHASE_CODE_STATUS: begin
                if (crlf) begin
                    r.st_done = 1'b1;
                    ps_phase = hrbp_pkg::PHASE_CODE_HEADERS;
                    clear_line();
                end else begin
                    ps_prev_cr = (c == hrbp_pkg::CHAR_CR);
                end
            end
            hrbp_pkg::PHASE_CODE_HEADERS: begin
                if (crlf && ps_line_count == 2'd1) begin
                    r.h_done = 1'b1;
                    ps_left = ps_len_seen ? (ps_accum & LEN_MASK) : 64'd0;
                    ps_phase = hrbp_pkg::PHASE_CODE_BODY;
                    clear_line();
                end else begin
                    if (ps_key_st == hrbp_pkg::KEY_MATCHING) begin
                        if (c == hrbp_pkg::CHAR_COLON)
                            ps_key_st = (ps_key_idx == hrbp_pkg::KEY_LEN) ?
                                        hrbp_pkg::KEY_MATCHED : hrbp_pkg::KEY_FAILED;
                        else if (ps_key_idx < hrbp_pkg::KEY_LEN && c == CL_KEY[ps_key_idx])
                            ps_key_idx++;
                        else
                            ps_key_st = hrbp_pkg::KEY_FAILED;
                    end
                    if (!ps_len_seen && ps_space) feed_number(c);
                    if (c == hrbp_pkg::CHAR_SPACE) ps_space = 1'b1;
                    if (crlf) begin
                        r.hl_done = 1'b1;
                        if (ps_key_st == hrbp_pkg::KEY_MATCHED && ps_space && !ps_len_seen) begin
                            ps_accum = clamped_length();
                            ps_len_seen = 1'b1;
                        end
                        clear_line();
                    end else begin
                        ps_prev_cr = (c == hrbp_pkg::CHAR_CR);
                        if (ps_line_count < 2'd3) ps_line_count++;
                    end
                end
            end
            hrbp_pkg::PHASE_CODE_BODY: begin
                r.is_body = 1'b1;
                if (ps_left <= 64'd1 || (ps_left & LEN_SIGN) != 0) begin
                    r.body_last = 1'b1;
                    ps_phase = hrbp_pkg::PHASE_CODE_DONE;
                end
                ps_left = (ps_left - 64'd1) & LEN_MASK;
            end
            default: ;
        endcase
        r.phase = ps_phase;
        r.len_known = ps_len_seen;
        r.body_len = ps_len_seen ? ps_accum[31:0] : 32'd0;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_output();
        t_parse_out want;
        if (parser_out_q.size() == 0) begin
            $error("output transfer with nothing pending: tdata %h", m_tdata);
            mismatches++;
            return;
        end
        want = parser_out_q.pop_front();
        compare_field("byte_echo", 32'(want.echo), 32'(m_tdata[7:0]));
        compare_field("status_line_done", 32'(want.st_done), 32'(m_tdata[8]));
        compare_field("header_line_done", 32'(want.hl_done), 32'(m_tdata[9]));
        compare_field("headers_done", 32'(want.h_done), 32'(m_tdata[10]));
        compare_field("length_known", 32'(want.len_known), 32'(m_tdata[11]));
        compare_field("body_length", want.body_len, m_tdata[43:12]);
        compare_field("phase", 32'(want.phase), 32'(m_tuser[1:0]));
        compare_field("is_body", 32'(want.is_body), 32'(m_tuser[2]));
        compare_field("body_last", 32'(want.body_last), 32'(m_tlast));
    endtask

    // output side: random stall bursts, none once the run calms down
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) check_output();
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        t_parse_out r;
        calm = (sent_count >= ITEM_GOAL - CALM_ITEMS);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge i_clk); while (!s_tready);
        r = parse_byte(b);
        parser_out_q.push_back(r);
        sent_count++;
    endtask

    task automatic send_line(input logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i]);
        send_byte(hrbp_pkg::CHAR_CR);
        send_byte(hrbp_pkg::CHAR_LF);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (parser_out_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic void push_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic void push_noise(ref logic [7:0] q[$], input int n);
        logic [7:0] b;
        logic prev_cr;
        prev_cr = 1'b0;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            // keep a stray CR LF from ending the line early
            if (prev_cr && b == hrbp_pkg::CHAR_LF) b = hrbp_pkg::CHAR_SPACE;
            prev_cr = (b == hrbp_pkg::CHAR_CR);
            q.push_back(b);
        end
    endfunction

    function automatic void push_digits(ref logic [7:0] q[$]);
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: push_text(q, $sformatf("%0d", $urandom_range(1, 300)));
            5: push_text(q, ($urandom_range(0, 1) != 0) ? "0" : "000");
            6: begin
                n = $urandom_range(10, 22);
                repeat (n) q.push_back(8'(hrbp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            end
            7: case ($urandom_range(0, 2))
                0: push_text(q, "2147483647");
                1: push_text(q, "2147483648");
                default: push_text(q, "2147483649");
            endcase
            8: push_text(q, "abc");
            default: push_text(q, $sformatf("%0d", $urandom_range(301, 100000)));
        endcase
    endfunction

    function automatic void push_length_value(ref logic [7:0] q[$]);
        int n;
        logic [7:0] w;
        if ($urandom_range(0, 4) == 0) push_noise(q, 0);
        if ($urandom_range(0, 4) == 0) push_text(q, "7");
        q.push_back(hrbp_pkg::CHAR_SPACE);
        n = $urandom_range(0, 2);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0: w = hrbp_pkg::CHAR_SPACE;
                1: w = hrbp_pkg::CHAR_TAB;
                2: w = hrbp_pkg::CHAR_TAB + 8'd2;   // VT
                3: w = hrbp_pkg::CHAR_TAB + 8'd3;   // FF
                4: w = hrbp_pkg::CHAR_CR;
                default: w = (q[q.size()-1] == hrbp_pkg::CHAR_CR) ?
                             hrbp_pkg::CHAR_SPACE : hrbp_pkg::CHAR_LF;
            endcase
            q.push_back(w);
        end
        case ($urandom_range(0, 7))
            6: q.push_back(hrbp_pkg::CHAR_PLUS);
            7: q.push_back(hrbp_pkg::CHAR_MINUS);
            default: ;
        endcase
        push_digits(q);
        case ($urandom_range(0, 3))
            0: push_text(q, " 12");
            1: push_text(q, "z");
            default: ;
        endcase
    endfunction

    task automatic send_header_line(input bit allow_length);
        logic [7:0] q[$];
        int k;
        k = $urandom_range(0, 9);
        if (!allow_length && k >= 7) k = 0;
        case (k)
            0, 1, 2, 3: push_noise(q, $urandom_range(1, 24));
            4: begin
                push_text(q, "X-Tag: ");
                repeat ($urandom_range(0, 8)) q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            5, 6: case ($urandom_range(0, 5))
                // colon but no space: skipped
                0: push_text(q, "Content-Length:42");
                // space ahead of the colon breaks the key
                1: push_text(q, "Content-Length : 42");
                2: push_text(q, "content-length: 42");
                3: push_text(q, "Content-Lengt: 42");
                4: push_text(q, "Content-Lengthy: 42");
                default: push_text(q, "Content-Length 42");
            endcase
            default: begin
                push_text(q, "Content-Length:");
                push_length_value(q);
            end
        endcase
        send_line(q);
    endtask

    task automatic run_status_line();
        logic [7:0] q[$];
        // lone LF and lone CR before the real end, which is CR CR LF
        q = {8'h00, hrbp_pkg::CHAR_LF, 8'hFF, hrbp_pkg::CHAR_CR, 8'h41,
             hrbp_pkg::CHAR_CR, hrbp_pkg::CHAR_CR, hrbp_pkg::CHAR_LF};
        foreach (q[i]) send_byte(q[i]);
    endtask

    task automatic run_header_edges();
        logic [7:0] q[$];
        q = {hrbp_pkg::CHAR_CR};
        send_line(q);
        q = {8'hFF};
        send_line(q);
        q = {hrbp_pkg::CHAR_COLON, hrbp_pkg::CHAR_SPACE, 8'h00};
        send_line(q);
    endtask

    task automatic run_random_headers();
        bit allow_length;
        int start;
        allow_length = ($urandom_range(0, 7) != 0);
        start = sent_count;
        while (sent_count - start < HEADER_BYTES) send_header_line(allow_length);
    endtask

    task automatic run_body();
        longint n;
        int extra;
        send_byte(hrbp_pkg::CHAR_CR);
        send_byte(hrbp_pkg::CHAR_LF);
        if (ps_left == 64'd0 || ps_left[hrbp_pkg::DEF_LENGTH_BITS-1])
            n = 1;
        else if (ps_left <= MAX_BODY)
            n = ps_left;
        else
            n = 0;
        if (n > 0) begin
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end else begin
            while (sent_count < ITEM_GOAL) send_byte(8'($urandom_range(0, 255)));
        end
        // bytes past completion are only echoed
        extra = (ITEM_GOAL - sent_count > 12) ? ITEM_GOAL - sent_count : 12;
        repeat (extra) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_status_line();
        run_header_edges();
        wait_drained();
        run_random_headers();
        run_body();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("** http_response_byte_parser_top: PASSED **");
        else
            $display("** http_response_byte_parser_top: FAILED **");
        $finish;
    end

    initial begin
        #5ms;
        $display("** http_response_byte_parser_top: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/hrbp_pkg.sv
rtl/core/hrbp_step.sv
rtl/core/http_response_byte_parser_top.sv
rtl/core/hrbp_checker.sv
tb/sv/http_response_byte_parser_top_tb.sv
